// ----- design/rebc_pkg.sv -----
package rebc_pkg;

  localparam int unsigned DEBOUNCE_W = 24;
  localparam int unsigned HOLD_W     = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 24'd10000;
  localparam logic [HOLD_W-1:0]     HOLD_RESET     = 32'd2000000;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 1'd1;

  localparam logic signed [COUNT_W-1:0] STEP_MAX  = 16'sh7fff;
  localparam logic signed [COUNT_W-1:0] STEP_MIN  = 16'sh8000;
  localparam logic [COUNT_W-1:0]        COUNT_MAX = 16'hffff;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  enc_a;
    logic  enc_b;
    logic  button_level;
  } req_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] step_count;
    logic [COUNT_W-1:0]        click_count;
    logic [COUNT_W-1:0]        hold_count;
  } rsp_t;

  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

// ----- design/rebc_if.sv -----
interface rebc_req_if;
  logic valid;
  logic ready;
  logic kind;
  logic enc_a;
  logic enc_b;
  logic button_level;

  modport source (output valid, output kind, output enc_a, output enc_b,
                  output button_level, input ready);
  modport sink   (input valid, input kind, input enc_a, input enc_b,
                  input button_level, output ready);
endinterface

interface rebc_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] step_count;
  logic [15:0]        click_count;
  logic [15:0]        hold_count;

  modport source (output valid, output step_count, output click_count,
                  output hold_count, input ready);
  modport sink   (input valid, input step_count, input click_count,
                  input hold_count, output ready);
endinterface

// ----- design/rebc_in_stage.sv -----
module rebc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  rebc_req_if.sink          in_ch,
  input  logic              advance,
  output rebc_pkg::stage_ctl_t s1_ctl,
  output rebc_pkg::req_t    s1_req
);
  import rebc_pkg::*;

  logic valid_r;
  logic valid_nxt;
  req_t req_r;
  logic in_fire;

  assign in_ch.ready = !valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= '{kind:         kind_t'(in_ch.kind),
                 enc_a:        in_ch.enc_a,
                 enc_b:        in_ch.enc_b,
                 button_level: in_ch.button_level};
    end
  end

  assign s1_ctl = '{valid: valid_r, advance: advance};
  assign s1_req = req_r;

endmodule

// ----- design/rebc_core.sv -----
module rebc_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rebc_pkg::stage_ctl_t                s1_ctl,
  input  rebc_pkg::req_t                      s1_req,
  input  logic                                out_free,
  input  logic [rebc_pkg::DEBOUNCE_W-1:0]     debounce,
  input  logic [rebc_pkg::HOLD_W-1:0]         hold,
  output logic                                advance,
  output logic                                rsp_valid,
  output rebc_pkg::rsp_t                      rsp
);
  import rebc_pkg::*;

  logic [TIME_W-1:0]         time_r, time_nxt;
  logic [TIME_W-1:0]         enc_time_r, enc_time_nxt;
  logic                      a_prev_r, a_prev_nxt;
  logic [TIME_W-1:0]         btn_time_r, btn_time_nxt;
  logic                      btn_prev_r, btn_prev_nxt;
  logic                      btn_held_r, btn_held_nxt;
  logic [TIME_W-1:0]         press_time_r, press_time_nxt;
  logic signed [COUNT_W-1:0] steps_r, steps_nxt;
  logic [COUNT_W-1:0]        clicks_r, clicks_nxt;
  logic [COUNT_W-1:0]        holds_r, holds_nxt;

  logic              is_tick;
  logic              is_read;
  logic [TIME_W-1:0] time_inc;
  logic [TIME_W-1:0] enc_gap;
  logic [TIME_W-1:0] btn_gap;
  logic [TIME_W-1:0] press_gap;
  logic [TIME_W-1:0] debounce_ext;
  logic              enc_due;
  logic              btn_due;

  assign advance   = s1_ctl.valid && (s1_req.kind == KIND_TICK || out_free);
  assign is_tick   = advance && s1_req.kind == KIND_TICK;
  assign is_read   = advance && s1_req.kind == KIND_READ;
  assign rsp_valid = is_read;
  assign rsp       = '{step_count: steps_r, click_count: clicks_r, hold_count: holds_r};

  assign time_inc     = time_r + TIME_W'(1);
  assign debounce_ext = TIME_W'(debounce);
  assign enc_gap      = time_inc - enc_time_r;
  assign btn_gap      = time_inc - btn_time_r;
  assign press_gap    = time_inc - press_time_r;
  assign enc_due      = enc_gap >= debounce_ext;
  assign btn_due      = btn_gap > debounce_ext;

  always_comb begin
    time_nxt       = time_r;
    enc_time_nxt   = enc_time_r;
    a_prev_nxt     = a_prev_r;
    btn_time_nxt   = btn_time_r;
    btn_prev_nxt   = btn_prev_r;
    btn_held_nxt   = btn_held_r;
    press_time_nxt = press_time_r;
    steps_nxt      = steps_r;
    clicks_nxt     = clicks_r;
    holds_nxt      = holds_r;

    if (is_read) begin
      steps_nxt  = '0;
      clicks_nxt = '0;
      holds_nxt  = '0;
    end

    if (is_tick) begin
      time_nxt = time_inc;

      if (enc_due) begin
        enc_time_nxt = time_inc;
        a_prev_nxt   = s1_req.enc_a;
        if (!a_prev_r && s1_req.enc_a) begin
          if (s1_req.enc_b) begin
            if (steps_r != STEP_MAX) steps_nxt = steps_r + COUNT_W'(1);
          end else begin
            if (steps_r != STEP_MIN) steps_nxt = steps_r - COUNT_W'(1);
          end
        end
      end

      if (btn_due) begin
        btn_time_nxt = time_inc;
        btn_prev_nxt = s1_req.button_level;
        if (btn_prev_r && !s1_req.button_level) begin
          press_time_nxt = time_inc;
          if (clicks_r != COUNT_MAX) clicks_nxt = clicks_r + COUNT_W'(1);
        end else if (!btn_prev_r && s1_req.button_level) begin
          btn_held_nxt = 1'b0;
        end else if (!btn_prev_r && !btn_held_r && press_gap > hold) begin
          btn_held_nxt = 1'b1;
          if (holds_r != COUNT_MAX) holds_nxt = holds_r + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r       <= '0;
      enc_time_r   <= '0;
      a_prev_r     <= 1'b0;
      btn_time_r   <= '0;
      btn_prev_r   <= 1'b1;
      btn_held_r   <= 1'b0;
      press_time_r <= '0;
      steps_r      <= '0;
      clicks_r     <= '0;
      holds_r      <= '0;
    end else begin
      time_r       <= time_nxt;
      enc_time_r   <= enc_time_nxt;
      a_prev_r     <= a_prev_nxt;
      btn_time_r   <= btn_time_nxt;
      btn_prev_r   <= btn_prev_nxt;
      btn_held_r   <= btn_held_nxt;
      press_time_r <= press_time_nxt;
      steps_r      <= steps_nxt;
      clicks_r     <= clicks_nxt;
      holds_r      <= holds_nxt;
    end
  end

  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    is_read |=> steps_r == '0 && clicks_r == '0 && holds_r == '0)
    else $error("counters not cleared after read");

  a_time_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !is_tick |=> $stable(time_r))
    else $error("time advanced without a tick");

  a_held_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    btn_held_r |-> !btn_prev_r)
    else $error("hold flag set while switch released");

endmodule

// ----- design/rebc_out_reg.sv -----
module rebc_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rsp_valid,
  input  rebc_pkg::rsp_t rsp,
  output logic           out_free,
  rebc_rsp_if.source     out_ch
);
  import rebc_pkg::*;

  logic valid_r;
  logic valid_nxt;
  rsp_t rsp_r;

  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (rsp_valid) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_valid) begin
      rsp_r <= rsp;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.step_count  = rsp_r.step_count;
  assign out_ch.click_count = rsp_r.click_count;
  assign out_ch.hold_count  = rsp_r.hold_count;

endmodule

// ----- design/rotary_encoder_button_counter.sv -----
// Channel | Dir | Handshake         | Payload
// in_ch   | in  | valid/ready       | kind, enc_a, enc_b, button_level
// out_ch  | out | valid/ready       | step_count, click_count, hold_count
// cfg     | in  | cfg_we, no ready  | cfg_index, cfg_wdata
//
// One request per clock unless a read is stalled; requests are registered in the
// input register before the counters, and a read's result in the output register.
// Reset is synchronous on rst_n; config returns to 10000 / 2000000 ticks.
// A stalled result holds the next read in the input register and the requests
// behind it wait; tick requests ahead of that read keep flowing.
module rotary_encoder_button_counter (
  input  logic                               clk,
  input  logic                               rst_n,
  rebc_req_if.sink                           in_ch,
  rebc_rsp_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [rebc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rebc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import rebc_pkg::*;

  logic [DEBOUNCE_W-1:0] debounce_r;
  logic [HOLD_W-1:0]     hold_r;

  stage_ctl_t s1_ctl;
  req_t       s1_req;
  logic       advance;
  logic       out_free;
  logic       rsp_valid;
  rsp_t       rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      hold_r     <= HOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: debounce_r <= cfg_wdata[DEBOUNCE_W-1:0];
        REG_HOLD:     hold_r     <= cfg_wdata[HOLD_W-1:0];
        default:      ;
      endcase
    end
  end

  rebc_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .s1_ctl  (s1_ctl),
    .s1_req  (s1_req)
  );

  rebc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_ctl    (s1_ctl),
    .s1_req    (s1_req),
    .out_free  (out_free),
    .debounce  (debounce_r),
    .hold      (hold_r),
    .advance   (advance),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  rebc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .out_free  (out_free),
    .out_ch    (out_ch)
  );

endmodule
